@@ sv/stmt_pkg.sv @@
`timescale 1ns / 1ps

package stmt_pkg;

  localparam int NUM_TRACKS           = 4;
  localparam int MAX_FRAMES_PER_BLOCK = 1024;

  localparam int SMP_W  = 16;
  localparam int LANE_W = 16;
  localparam int FAC_W  = 15;
  localparam int GAIN_W = LANE_W + FAC_W;
  localparam int PROD_W = SMP_W + GAIN_W;
  localparam int SUM_W  = PROD_W + $clog2(NUM_TRACKS) + 1;
  localparam int MIX_W  = 24;
  localparam int FRAC_SHIFT = 26;
  localparam int POS_W  = 32;
  localparam int BLK_W  = $clog2(MAX_FRAMES_PER_BLOCK) + 1;

  localparam int REG_W   = 64;
  localparam int ADDR_W  = 6;
  localparam int IDX_LSB = 3;

  localparam logic signed [LANE_W-1:0] UNITY_PAN = 16'sd16384;
  localparam logic [REG_W-1:0] VOLUME_RESET = 64'h1000_1000_1000_1000;

  typedef enum logic [2:0] {
    REG_TRACK_VOLUMES = 3'd0,
    REG_TRACK_PANS    = 3'd1,
    REG_MUTE_MASK     = 3'd2,
    REG_SOLO_MASK     = 3'd3,
    REG_TRANSPORT_RUN = 3'd4,
    REG_LOOP_ENABLE   = 3'd5,
    REG_LOOP_START    = 3'd6,
    REG_LOOP_END      = 3'd7
  } reg_idx_t;

  // Load strobes that walk one transaction through the lane stages.
  typedef struct packed {
    logic ld_in;
    logic ld_gain;
    logic ld_prod;
  } lane_ctrl_t;

  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

@@ sv/stmt_lane.sv @@
`timescale 1ns / 1ps

module stmt_lane (
  input  logic                                clk,
  input  stmt_pkg::lane_ctrl_t                ctrl,
  input  logic        [stmt_pkg::LANE_W-1:0]  vol,
  input  logic signed [stmt_pkg::LANE_W-1:0]  pan,
  input  logic                                active,
  input  logic signed [stmt_pkg::SMP_W-1:0]   smp_l,
  input  logic signed [stmt_pkg::SMP_W-1:0]   smp_r,
  output stmt_pkg::prod_t                     prod_l,
  output stmt_pkg::prod_t                     prod_r
);

  logic signed [stmt_pkg::SMP_W-1:0]  smp_l_r, smp_r_r;
  logic                               active_r;
  logic        [stmt_pkg::GAIN_W-1:0] gain_l_r, gain_r_r;
  logic        [stmt_pkg::GAIN_W-1:0] gain_l_nxt, gain_r_nxt;
  stmt_pkg::prod_t                    prod_l_r, prod_r_r;
  stmt_pkg::prod_t                    prod_l_nxt, prod_r_nxt;
  logic signed [stmt_pkg::LANE_W-1:0] pan_c, fac_l16, fac_r16;
  logic        [stmt_pkg::FAC_W-1:0]  fac_l, fac_r;

  // Linear pan law: only the side opposite the pan direction is attenuated.
  always_comb begin
    pan_c = pan;
    if (pan > stmt_pkg::UNITY_PAN) pan_c = stmt_pkg::UNITY_PAN;
    if (pan < -stmt_pkg::UNITY_PAN) pan_c = -stmt_pkg::UNITY_PAN;
    fac_l16 = (pan_c <= 0) ? stmt_pkg::UNITY_PAN : stmt_pkg::UNITY_PAN - pan_c;
    fac_r16 = (pan_c >= 0) ? stmt_pkg::UNITY_PAN : stmt_pkg::UNITY_PAN + pan_c;
    fac_l = fac_l16[stmt_pkg::FAC_W-1:0];
    fac_r = fac_r16[stmt_pkg::FAC_W-1:0];
    gain_l_nxt = stmt_pkg::GAIN_W'(vol) * stmt_pkg::GAIN_W'(fac_l);
    gain_r_nxt = stmt_pkg::GAIN_W'(vol) * stmt_pkg::GAIN_W'(fac_r);
    prod_l_nxt = '0;
    prod_r_nxt = '0;
    if (active_r) begin
      prod_l_nxt = stmt_pkg::PROD_W'(smp_l_r) * $signed({1'b0, gain_l_r});
      prod_r_nxt = stmt_pkg::PROD_W'(smp_r_r) * $signed({1'b0, gain_r_r});
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      smp_l_r  <= smp_l;
      smp_r_r  <= smp_r;
      active_r <= active;
    end
    if (ctrl.ld_gain) begin
      gain_l_r <= gain_l_nxt;
      gain_r_r <= gain_r_nxt;
    end
    if (ctrl.ld_prod) begin
      prod_l_r <= prod_l_nxt;
      prod_r_r <= prod_r_nxt;
    end
  end

  assign prod_l = prod_l_r;
  assign prod_r = prod_r_r;

endmodule

@@ sv/stmt_merge.sv @@
`timescale 1ns / 1ps

module stmt_merge (
  input  stmt_pkg::prod_t                   prod_l [stmt_pkg::NUM_TRACKS],
  input  stmt_pkg::prod_t                   prod_r [stmt_pkg::NUM_TRACKS],
  output logic signed [stmt_pkg::MIX_W-1:0] mix_l,
  output logic signed [stmt_pkg::MIX_W-1:0] mix_r
);

  localparam int RES_W = stmt_pkg::SUM_W - stmt_pkg::FRAC_SHIFT;
  localparam logic signed [stmt_pkg::SUM_W-1:0] HALF =
    stmt_pkg::SUM_W'(1) <<< (stmt_pkg::FRAC_SHIFT - 1);
  localparam logic signed [RES_W-1:0] MIX_MAX = RES_W'((1 << (stmt_pkg::MIX_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] MIX_MIN = -RES_W'(1 << (stmt_pkg::MIX_W - 1));

  logic signed [stmt_pkg::SUM_W-1:0] sum_l, sum_r, sh_l, sh_r;
  logic signed [RES_W-1:0]           res_l, res_r;

  // Round to nearest with ties toward plus infinity: add half, then floor.
  always_comb begin
    sum_l = HALF;
    sum_r = HALF;
    for (int k = 0; k < stmt_pkg::NUM_TRACKS; k++) begin
      sum_l = sum_l + stmt_pkg::SUM_W'(prod_l[k]);
      sum_r = sum_r + stmt_pkg::SUM_W'(prod_r[k]);
    end
    sh_l  = sum_l >>> stmt_pkg::FRAC_SHIFT;
    sh_r  = sum_r >>> stmt_pkg::FRAC_SHIFT;
    res_l = sh_l[RES_W-1:0];
    res_r = sh_r[RES_W-1:0];
    if (res_l > MIX_MAX) res_l = MIX_MAX;
    if (res_l < MIX_MIN) res_l = MIX_MIN;
    if (res_r > MIX_MAX) res_r = MIX_MAX;
    if (res_r < MIX_MIN) res_r = MIX_MIN;
    mix_l = stmt_pkg::MIX_W'(res_l);
    mix_r = stmt_pkg::MIX_W'(res_r);
  end

endmodule

@@ sv/stereo_track_mixer_with_transport_top.sv @@
`timescale 1ns / 1ps

// Four-track stereo mixer with a playhead. Each input transaction carries one
// stereo frame per track and yields one output transaction with the mixed
// left/right samples and the playhead frame of that input. After a frame is
// accepted, the four lanes form their pan gains in parallel, then their sample
// products, and the merge stage sums, rounds and loads the output register. The
// input is stalled until the output register is loaded, which waits for as long
// as the previous result has not been taken, so no new frame is accepted while
// one is in flight. Registers must be written over the APB port only while no
// frame is in flight; the block itself does not enforce this.
module stereo_track_mixer_with_transport_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track0_left,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track0_right,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track1_left,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track1_right,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track2_left,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track2_right,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track3_left,
  input  logic signed [stmt_pkg::SMP_W-1:0]    in_track3_right,
  input  logic                                 in_block_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [stmt_pkg::MIX_W-1:0]    out_mix_left,
  output logic signed [stmt_pkg::MIX_W-1:0]    out_mix_right,
  output logic        [stmt_pkg::POS_W-1:0]    out_frame_position,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [stmt_pkg::ADDR_W-1:0]   paddr,
  input  logic        [stmt_pkg::REG_W-1:0]    pwdata,
  output logic        [stmt_pkg::REG_W-1:0]    prdata,
  output logic                                 pready
);

  localparam int TC = stmt_pkg::NUM_TRACKS;
  localparam logic [stmt_pkg::BLK_W-1:0] BLK_LAST =
    stmt_pkg::BLK_W'(stmt_pkg::MAX_FRAMES_PER_BLOCK - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_GAIN,
    S_PROD,
    S_MERGE
  } state_t;

  state_t state_r, state_nxt;

  logic [stmt_pkg::REG_W-1:0] vol_r, pan_r;
  logic [TC-1:0]              mute_r, solo_r;
  logic                       run_r, loop_en_r;
  logic [stmt_pkg::POS_W-1:0] loop_start_r, loop_end_r;

  logic [stmt_pkg::POS_W-1:0] playhead_r, playhead_nxt;
  logic [stmt_pkg::BLK_W-1:0] blk_off_r, blk_off_nxt;
  logic [stmt_pkg::POS_W-1:0] pos_r, pos_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic signed [stmt_pkg::MIX_W-1:0] mix_l_r, mix_r_r, mix_l, mix_r;
  logic        [stmt_pkg::POS_W-1:0] out_pos_r;

  logic                       cfg_wr, accept, out_free, load_out, last;
  stmt_pkg::reg_idx_t         cfg_idx;
  stmt_pkg::lane_ctrl_t       ctrl;
  logic [TC-1:0]              active;
  logic [stmt_pkg::POS_W:0]   adv, thr;

  logic signed [stmt_pkg::SMP_W-1:0] smp_l [TC];
  logic signed [stmt_pkg::SMP_W-1:0] smp_r [TC];
  stmt_pkg::prod_t                   prod_l [TC];
  stmt_pkg::prod_t                   prod_r [TC];

  assign smp_l[0] = in_track0_left;
  assign smp_r[0] = in_track0_right;
  assign smp_l[1] = in_track1_left;
  assign smp_r[1] = in_track1_right;
  assign smp_l[2] = in_track2_left;
  assign smp_r[2] = in_track2_right;
  assign smp_l[3] = in_track3_left;
  assign smp_r[3] = in_track3_right;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = stmt_pkg::reg_idx_t'(paddr[stmt_pkg::ADDR_W-1:stmt_pkg::IDX_LSB]);

  always_comb begin
    case (cfg_idx)
      stmt_pkg::REG_TRACK_VOLUMES: prdata = vol_r;
      stmt_pkg::REG_TRACK_PANS:    prdata = pan_r;
      stmt_pkg::REG_MUTE_MASK:     prdata = stmt_pkg::REG_W'(mute_r);
      stmt_pkg::REG_SOLO_MASK:     prdata = stmt_pkg::REG_W'(solo_r);
      stmt_pkg::REG_TRANSPORT_RUN: prdata = stmt_pkg::REG_W'(run_r);
      stmt_pkg::REG_LOOP_ENABLE:   prdata = stmt_pkg::REG_W'(loop_en_r);
      stmt_pkg::REG_LOOP_START:    prdata = stmt_pkg::REG_W'(loop_start_r);
      stmt_pkg::REG_LOOP_END:      prdata = stmt_pkg::REG_W'(loop_end_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r        <= stmt_pkg::VOLUME_RESET;
      pan_r        <= '0;
      mute_r       <= '0;
      solo_r       <= '0;
      run_r        <= 1'b0;
      loop_en_r    <= 1'b0;
      loop_start_r <= '0;
      loop_end_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        stmt_pkg::REG_TRACK_VOLUMES: vol_r        <= pwdata;
        stmt_pkg::REG_TRACK_PANS:    pan_r        <= pwdata;
        stmt_pkg::REG_MUTE_MASK:     mute_r       <= pwdata[TC-1:0];
        stmt_pkg::REG_SOLO_MASK:     solo_r       <= pwdata[TC-1:0];
        stmt_pkg::REG_TRANSPORT_RUN: run_r        <= pwdata[0];
        stmt_pkg::REG_LOOP_ENABLE:   loop_en_r    <= pwdata[0];
        stmt_pkg::REG_LOOP_START:    loop_start_r <= pwdata[stmt_pkg::POS_W-1:0];
        stmt_pkg::REG_LOOP_END:      loop_end_r   <= pwdata[stmt_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  // A stopped transport, a mute, or a solo on another track silences a lane.
  always_comb begin
    for (int k = 0; k < TC; k++) begin
      active[k] = run_r & ~mute_r[k] & ~((|solo_r) & ~solo_r[k]);
    end
  end

  genvar g;
  generate
    for (g = 0; g < TC; g++) begin : g_lane
      stmt_lane u_lane (
        .clk    (clk),
        .ctrl   (ctrl),
        .vol    (vol_r[stmt_pkg::LANE_W*g +: stmt_pkg::LANE_W]),
        .pan    ($signed(pan_r[stmt_pkg::LANE_W*g +: stmt_pkg::LANE_W])),
        .active (active[g]),
        .smp_l  (smp_l[g]),
        .smp_r  (smp_r[g]),
        .prod_l (prod_l[g]),
        .prod_r (prod_r[g])
      );
    end
  endgenerate

  stmt_merge u_merge (
    .prod_l (prod_l),
    .prod_r (prod_r),
    .mix_l  (mix_l),
    .mix_r  (mix_r)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign load_out = (state_r == S_MERGE) & out_free;

  always_comb begin
    ctrl.ld_in   = accept;
    ctrl.ld_gain = (state_r == S_GAIN);
    ctrl.ld_prod = (state_r == S_PROD);
  end

  always_comb begin
    state_nxt     = state_r;
    playhead_nxt  = playhead_r;
    blk_off_nxt   = blk_off_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r & out_stall;
    last = in_block_end | (blk_off_r >= BLK_LAST);
    adv  = {1'b0, playhead_r} + (stmt_pkg::POS_W + 1)'(blk_off_r)
           + (stmt_pkg::POS_W + 1)'(1);
    thr  = {1'b0, loop_start_r} + (stmt_pkg::POS_W + 1)'(1);
    if ({1'b0, loop_end_r} > thr) thr = {1'b0, loop_end_r};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_GAIN;
          pos_nxt   = playhead_r + stmt_pkg::POS_W'(blk_off_r);
          if (last) begin
            blk_off_nxt = '0;
            if (run_r) begin
              if (loop_en_r && adv >= thr) playhead_nxt = loop_start_r;
              else playhead_nxt = adv[stmt_pkg::POS_W-1:0];
            end
          end else begin
            blk_off_nxt = blk_off_r + stmt_pkg::BLK_W'(1);
          end
        end
      end
      S_GAIN:  state_nxt = S_PROD;
      S_PROD:  state_nxt = S_MERGE;
      S_MERGE: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      playhead_r  <= '0;
      blk_off_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      playhead_r  <= playhead_nxt;
      blk_off_r   <= blk_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r <= pos_nxt;
    if (load_out) begin
      mix_l_r   <= mix_l;
      mix_r_r   <= mix_r;
      out_pos_r <= pos_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mix_left       = mix_l_r;
  assign out_mix_right      = mix_r_r;
  assign out_frame_position = out_pos_r;

endmodule

@@ dv/stereo_track_mixer_with_transport_top_tb.sv @@
`timescale 1ns / 1ps

module stereo_track_mixer_with_transport_top_tb;

  typedef logic signed [stmt_pkg::SMP_W-1:0] sample_t;

  typedef struct packed {
    logic [stmt_pkg::NUM_TRACKS-1:0][stmt_pkg::SMP_W-1:0] left;
    logic [stmt_pkg::NUM_TRACKS-1:0][stmt_pkg::SMP_W-1:0] right;
    logic                                                 block_end;
  } frame_t;

  typedef struct packed {
    logic signed [stmt_pkg::MIX_W-1:0] mix_left;
    logic signed [stmt_pkg::MIX_W-1:0] mix_right;
    logic [stmt_pkg::POS_W-1:0]        frame_position;
  } mix_t;

  localparam longint PAN_UNITY = longint'(stmt_pkg::UNITY_PAN);
  localparam longint MIX_HI    = (longint'(1) <<< (stmt_pkg::MIX_W - 1)) - 1;
  localparam longint MIX_LO    = -(longint'(1) <<< (stmt_pkg::MIX_W - 1));
  localparam int     HOLD_LEN  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t in_track0_left = '0;
  sample_t in_track0_right = '0;
  sample_t in_track1_left = '0;
  sample_t in_track1_right = '0;
  sample_t in_track2_left = '0;
  sample_t in_track2_right = '0;
  sample_t in_track3_left = '0;
  sample_t in_track3_right = '0;
  logic in_block_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [stmt_pkg::MIX_W-1:0] out_mix_left;
  logic signed [stmt_pkg::MIX_W-1:0] out_mix_right;
  logic [stmt_pkg::POS_W-1:0] out_frame_position;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [stmt_pkg::ADDR_W-1:0] paddr = '0;
  logic [stmt_pkg::REG_W-1:0] pwdata = '0;
  logic [stmt_pkg::REG_W-1:0] prdata;
  logic pready;

  // Shadow copy of the mixer registers and transport state.
  logic [stmt_pkg::REG_W-1:0] gain_volumes = stmt_pkg::VOLUME_RESET;
  logic [stmt_pkg::REG_W-1:0] gain_pans = '0;
  logic [stmt_pkg::NUM_TRACKS-1:0] muted_tracks = '0;
  logic [stmt_pkg::NUM_TRACKS-1:0] soloed_tracks = '0;
  logic playing = 1'b0;
  logic looping = 1'b0;
  logic [stmt_pkg::POS_W-1:0] loop_from = '0;
  logic [stmt_pkg::POS_W-1:0] loop_to = '0;
  logic [stmt_pkg::POS_W-1:0] playhead_pos = '0;
  int frames_in_block = 0;

  mix_t expected_mix[$];
  int error_count = 0;
  bit jitter_on = 1'b1;
  logic hold_active = 1'b0;

  stereo_track_mixer_with_transport_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_track0_left     (in_track0_left),
    .in_track0_right    (in_track0_right),
    .in_track1_left     (in_track1_left),
    .in_track1_right    (in_track1_right),
    .in_track2_left     (in_track2_left),
    .in_track2_right    (in_track2_right),
    .in_track3_left     (in_track3_left),
    .in_track3_right    (in_track3_right),
    .in_block_end       (in_block_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mix_left       (out_mix_left),
    .out_mix_right      (out_mix_right),
    .out_frame_position (out_frame_position),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #4 clk = ~clk;

  function automatic logic [stmt_pkg::MIX_W-1:0] round_to_mix(input longint acc);
    longint r;
    r = (acc + (longint'(1) <<< (stmt_pkg::FRAC_SHIFT - 1))) >>> stmt_pkg::FRAC_SHIFT;
    if (r > MIX_HI) r = MIX_HI;
    if (r < MIX_LO) r = MIX_LO;
    return r[stmt_pkg::MIX_W-1:0];
  endfunction

  // Mixes one frame with the current settings and, while the transport runs,
  // moves the playhead when the frame closes a block.
  function automatic mix_t mix_frame(input frame_t f);
    mix_t res;
    longint acc_l, acc_r, vol, pan, gl, gr;
    longint unsigned next_pos, thr;
    logic solo_present, last;
    acc_l = 0;
    acc_r = 0;
    solo_present = |soloed_tracks;
    res.frame_position = playhead_pos + stmt_pkg::POS_W'(frames_in_block);
    if (playing) begin
      for (int k = 0; k < stmt_pkg::NUM_TRACKS; k++) begin
        if (muted_tracks[k] || (solo_present && !soloed_tracks[k])) continue;
        vol = longint'(gain_volumes[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W]);
        pan = longint'($signed(gain_pans[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W]));
        if (pan > PAN_UNITY) pan = PAN_UNITY;
        if (pan < -PAN_UNITY) pan = -PAN_UNITY;
        gl = vol * (pan <= 0 ? PAN_UNITY : PAN_UNITY - pan);
        gr = vol * (pan >= 0 ? PAN_UNITY : PAN_UNITY + pan);
        acc_l += longint'($signed(f.left[k])) * gl;
        acc_r += longint'($signed(f.right[k])) * gr;
      end
    end
    res.mix_left = round_to_mix(acc_l);
    res.mix_right = round_to_mix(acc_r);

    last = f.block_end || (frames_in_block >= stmt_pkg::MAX_FRAMES_PER_BLOCK - 1);
    if (!last) begin
      frames_in_block++;
    end else begin
      if (playing) begin
        next_pos = longint'(playhead_pos) + longint'(frames_in_block) + 1;
        thr = longint'(loop_from) + 1;
        if (longint'(loop_to) > thr) thr = loop_to;
        if (looping && next_pos >= thr) next_pos = loop_from;
        playhead_pos = next_pos[stmt_pkg::POS_W-1:0];
      end
      frames_in_block = 0;
    end
    return res;
  endfunction

  task automatic note_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    mix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_mix.size() == 0) begin
        note_error($sformatf("Unexpected result L=%0d R=%0d pos=%0d",
                             out_mix_left, out_mix_right, out_frame_position));
      end else begin
        want = expected_mix.pop_front();
        if (out_mix_left !== want.mix_left || out_mix_right !== want.mix_right ||
            out_frame_position !== want.frame_position) begin
          note_error($sformatf(
            "Mismatch: expected L=%0d R=%0d pos=%0d, got L=%0d R=%0d pos=%0d",
            want.mix_left, want.mix_right, want.frame_position,
            out_mix_left, out_mix_right, out_frame_position));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_active || (jitter_on && $urandom_range(0, 99) < 11);
  end

  task automatic write_reg(input stmt_pkg::reg_idx_t idx,
                           input logic [stmt_pkg::REG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= stmt_pkg::ADDR_W'(idx) << stmt_pkg::IDX_LSB;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      stmt_pkg::REG_TRACK_VOLUMES: gain_volumes = value;
      stmt_pkg::REG_TRACK_PANS:    gain_pans = value;
      stmt_pkg::REG_MUTE_MASK:     muted_tracks = value[stmt_pkg::NUM_TRACKS-1:0];
      stmt_pkg::REG_SOLO_MASK:     soloed_tracks = value[stmt_pkg::NUM_TRACKS-1:0];
      stmt_pkg::REG_TRANSPORT_RUN: playing = value[0];
      stmt_pkg::REG_LOOP_ENABLE:   looping = value[0];
      stmt_pkg::REG_LOOP_START:    loop_from = value[stmt_pkg::POS_W-1:0];
      stmt_pkg::REG_LOOP_END:      loop_to = value[stmt_pkg::POS_W-1:0];
      default: ;
    endcase
  endtask

  // Narrow registers get random upper bits, which the block must drop.
  task automatic apply_setting(input logic [stmt_pkg::REG_W-1:0] vols,
                               input logic [stmt_pkg::REG_W-1:0] pans,
                               input logic [3:0] mute, input logic [3:0] solo,
                               input logic run, input logic loop_en,
                               input logic [31:0] lstart, input logic [31:0] lend);
    logic [stmt_pkg::REG_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(stmt_pkg::REG_TRACK_VOLUMES, vols);
    write_reg(stmt_pkg::REG_TRACK_PANS, pans);
    write_reg(stmt_pkg::REG_MUTE_MASK, {junk[63:4], mute});
    write_reg(stmt_pkg::REG_SOLO_MASK, {junk[62:3], solo});
    write_reg(stmt_pkg::REG_TRANSPORT_RUN, {junk[63:1], run});
    write_reg(stmt_pkg::REG_LOOP_ENABLE, {junk[62:0], loop_en});
    write_reg(stmt_pkg::REG_LOOP_START, {junk[31:0], lstart});
    write_reg(stmt_pkg::REG_LOOP_END, {junk[47:16], lend});
  endtask

  task automatic send_frame(input frame_t f);
    if (jitter_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_track0_left <= f.left[0];
    in_track0_right <= f.right[0];
    in_track1_left <= f.left[1];
    in_track1_right <= f.right[1];
    in_track2_left <= f.left[2];
    in_track2_right <= f.right[2];
    in_track3_left <= f.left[3];
    in_track3_right <= f.right[3];
    in_block_end <= f.block_end;
    do @(posedge clk); while (in_stall);
    expected_mix.insert(expected_mix.size(), mix_frame(f));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic frame_t same_frame(input sample_t l, input sample_t r, input logic be);
    frame_t f;
    for (int k = 0; k < stmt_pkg::NUM_TRACKS; k++) begin
      f.left[k] = l;
      f.right[k] = r;
    end
    f.block_end = be;
    return f;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame(input logic be);
    frame_t f;
    for (int k = 0; k < stmt_pkg::NUM_TRACKS; k++) begin
      f.left[k] = pick_sample();
      f.right[k] = pick_sample();
    end
    f.block_end = be;
    return f;
  endfunction

  // Out of reset the transport is stopped: silence, playhead held. Starting
  // it in the middle of a block still advances the playhead at block end.
  task automatic test_stopped_transport();
    send_frame(same_frame(16'sh7FFF, 16'sh8000, 1'b0));
    send_frame(same_frame(16'sh1234, -16'sd1, 1'b1));
    send_frame(same_frame(16'sh0000, 16'sh0000, 1'b0));
    wait_for_results();
    write_reg(stmt_pkg::REG_TRANSPORT_RUN, 64'd1);
    send_frame(same_frame(16'sh7FFF, 16'sh7FFF, 1'b1));
  endtask

  task automatic test_unity_mix();
    send_frame(same_frame(16'sh7FFF, 16'sh7FFF, 1'b0));
    send_frame(same_frame(16'sh8000, 16'sh8000, 1'b0));
    send_frame(same_frame(16'sh8000, 16'sh7FFF, 1'b0));
    send_frame(same_frame(16'sh0001, -16'sd1, 1'b1));
  endtask

  // With only track 0 at the smallest volume, +/-2048 lands exactly on a half.
  task automatic test_rounding_ties();
    wait_for_results();
    write_reg(stmt_pkg::REG_TRACK_VOLUMES, 64'h0000_0000_0000_0001);
    send_frame(same_frame(16'sd2048, -16'sd2048, 1'b0));
    send_frame(same_frame(-16'sd2048, 16'sd2048, 1'b0));
    send_frame(same_frame(16'sd6144, -16'sd6144, 1'b1));
    wait_for_results();
    write_reg(stmt_pkg::REG_TRACK_VOLUMES, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(same_frame(16'sh7FFF, 16'sh8000, 1'b1));
  endtask

  // Hard right, hard left, and two lanes past full scale that must clamp.
  task automatic test_pan_law();
    wait_for_results();
    write_reg(stmt_pkg::REG_TRACK_VOLUMES, stmt_pkg::VOLUME_RESET);
    write_reg(stmt_pkg::REG_TRACK_PANS, 64'h8000_7FFF_C000_4000);
    send_frame(random_frame(1'b0));
    send_frame(random_frame(1'b0));
    wait_for_results();
    write_reg(stmt_pkg::REG_TRACK_PANS, 64'h2000_E000_0001_FFFF);
    send_frame(random_frame(1'b0));
    send_frame(random_frame(1'b1));
  endtask

  task automatic test_mute_solo();
    wait_for_results();
    write_reg(stmt_pkg::REG_TRACK_PANS, 64'd0);
    write_reg(stmt_pkg::REG_MUTE_MASK, 64'b0101);
    send_frame(random_frame(1'b0));
    wait_for_results();
    write_reg(stmt_pkg::REG_SOLO_MASK, 64'b0010);
    send_frame(random_frame(1'b0));
    wait_for_results();
    // A soloed track that is also muted leaves nothing audible.
    write_reg(stmt_pkg::REG_SOLO_MASK, 64'b0001);
    send_frame(random_frame(1'b0));
    wait_for_results();
    write_reg(stmt_pkg::REG_SOLO_MASK, 64'b0000);
    write_reg(stmt_pkg::REG_MUTE_MASK, 64'b1111);
    send_frame(random_frame(1'b0));
    wait_for_results();
    write_reg(stmt_pkg::REG_MUTE_MASK, 64'b0000);
    write_reg(stmt_pkg::REG_SOLO_MASK, 64'b1111);
    send_frame(random_frame(1'b1));
  endtask

  task automatic test_loop_wrap();
    wait_for_results();
    write_reg(stmt_pkg::REG_SOLO_MASK, 64'd0);
    write_reg(stmt_pkg::REG_LOOP_START, 64'd2);
    write_reg(stmt_pkg::REG_LOOP_END, 64'd0);
    write_reg(stmt_pkg::REG_LOOP_ENABLE, 64'd1);
    // A loop end below the start still wraps one frame past the start.
    send_frame(random_frame(1'b1));
    send_frame(random_frame(1'b1));
    wait_for_results();
    write_reg(stmt_pkg::REG_LOOP_END, 64'd6);
    send_frame(random_frame(1'b0));
    send_frame(random_frame(1'b1));
    send_frame(random_frame(1'b0));
    send_frame(random_frame(1'b1));
    wait_for_results();
    write_reg(stmt_pkg::REG_LOOP_START, 64'hFFFF_FFFF);
    write_reg(stmt_pkg::REG_LOOP_END, 64'd0);
    send_frame(random_frame(1'b1));
    wait_for_results();
    write_reg(stmt_pkg::REG_LOOP_ENABLE, 64'd0);
  endtask

  // Stopping before the last frame of a block keeps the playhead where it is.
  task automatic test_stop_at_block_end();
    send_frame(random_frame(1'b0));
    wait_for_results();
    write_reg(stmt_pkg::REG_TRANSPORT_RUN, 64'd0);
    send_frame(random_frame(1'b1));
  endtask

  task automatic test_overlong_block();
    wait_for_results();
    apply_setting(stmt_pkg::VOLUME_RESET, 64'd0, 4'd0, 4'd0, 1'b1, 1'b0, 32'd0, 32'd0);
    repeat (stmt_pkg::MAX_FRAMES_PER_BLOCK + 6) send_frame(random_frame(1'b0));
    send_frame(random_frame(1'b1));
  endtask

  // The sink holds off long enough for the mixer to stall its input.
  task automatic test_backpressure();
    wait_for_results();
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
    repeat (60) send_frame(random_frame($urandom_range(0, 5) == 0));
  endtask

  task automatic test_random_traffic();
    logic [stmt_pkg::REG_W-1:0] vols, pans;
    logic [3:0] mute, solo;
    logic [31:0] lstart, lend;
    for (int phase = 0; phase < 9; phase++) begin
      wait_for_results();
      jitter_on = (phase != 4);
      for (int k = 0; k < stmt_pkg::NUM_TRACKS; k++) begin
        case ($urandom_range(0, 4))
          0: vols[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] = '0;
          1: vols[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] = 16'hFFFF;
          2: vols[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] = 16'h1000;
          default: vols[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] =
                     stmt_pkg::LANE_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0: pans[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] = 16'h4000;
          1: pans[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] = 16'hC000;
          2: pans[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] =
               stmt_pkg::LANE_W'($urandom_range(0, 32768) - 16384);
          3: pans[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] = '0;
          default: pans[stmt_pkg::LANE_W*k +: stmt_pkg::LANE_W] =
                     stmt_pkg::LANE_W'($urandom);
        endcase
      end
      if (phase == 1) vols = '1;
      if (phase == 2) vols = '0;
      mute = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
      solo = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
      lstart = ($urandom_range(0, 5) == 0) ? 32'($urandom) : 32'($urandom_range(0, 4000));
      lend = ($urandom_range(0, 5) == 0) ? 32'($urandom) : lstart + $urandom_range(0, 600);
      apply_setting(vols, pans, mute, solo, $urandom_range(0, 4) != 0,
                    1'($urandom_range(0, 1)), lstart, lend);
      repeat ((phase == 4) ? 60 : 20) send_frame(random_frame($urandom_range(0, 5) == 0));
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_stopped_transport();
    test_unity_mix();
    test_rounding_ties();
    test_pan_law();
    test_mute_solo();
    test_loop_wrap();
    test_stop_at_block_end();
    test_overlong_block();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && expected_mix.size() != 0; n++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (expected_mix.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_mix.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
